[sv/mrs_pkg.sv]
// Shared types, constants and CRC helper for the Modbus RTU slave frame block.
`timescale 1ns / 1ps
package mrs_pkg;

	localparam int FRAME_BYTES = 8;
	localparam int RX_WINDOW   = 32;
	localparam int IDX_W       = $clog2(FRAME_BYTES);
	localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
	localparam int WIN_W       = $clog2(RX_WINDOW + 1);
	localparam int CRC_BYTES   = 6;
	localparam int READ_BYTES  = 7;

	localparam logic [7:0]  CODE_READ     = 8'h03;
	localparam logic [7:0]  CODE_WRITE    = 8'h06;
	localparam logic [7:0]  REG_HI        = 8'h9C;
	localparam logic [7:0]  REG_READ_LO   = 8'h41;
	localparam logic [7:0]  REG_WRITE_LO  = 8'h44;
	localparam logic [7:0]  BUZZ_ON_VALUE = 8'h01;
	localparam logic [7:0]  READ_BYTECNT  = 8'h02;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;

	typedef struct packed {
		logic                            is_write;
		logic [FRAME_BYTES-1:0][7:0]     bytes;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
		logic [15:0] r;
		r = c ^ {8'h00, d};
		for (int b = 0; b < 8; b++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

[sv/mrs_front.sv]
// Front end: collects the frame, checks CRC and address, queues reply commands.
`timescale 1ns / 1ps
module mrs_front import mrs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic [7:0] rx_byte,
	input  logic [7:0] slave_address,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);

	typedef enum logic [1:0] {F_IDLE, F_CRC, F_CHECK} fstate_t;

	fstate_t          state_q;
	logic [7:0]       store_q [FRAME_BYTES];
	logic [CNT_W-1:0] cnt_q;
	logic [WIN_W-1:0] win_q;
	logic [15:0]      crc_q;
	logic [IDX_W-1:0] crc_idx_q;

	logic accept;
	logic crc_ok;
	logic is_read;
	logic is_write;
	logic cmd_ok;

	assign in_stall = (state_q != F_IDLE);
	assign accept   = in_valid && !in_stall;

	assign crc_ok = ((store_q[6] == crc_q[7:0]) && (store_q[7] == crc_q[15:8])) ||
	                ((store_q[6] == crc_q[15:8]) && (store_q[7] == crc_q[7:0]));
	assign is_read  = (store_q[1] == CODE_READ) && (store_q[2] == REG_HI) &&
	                  (store_q[3] == REG_READ_LO);
	assign is_write = (store_q[1] == CODE_WRITE);
	assign cmd_ok   = crc_ok && (store_q[0] == slave_address) && (is_read || is_write);

	assign push = (state_q == F_CHECK) && cmd_ok && !q_full;

	always_comb begin
		push_cmd.is_write = is_write;
		for (int i = 0; i < FRAME_BYTES; i++) begin
			push_cmd.bytes[i] = store_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			cnt_q     <= '0;
			win_q     <= '0;
			crc_q     <= CRC_INIT;
			crc_idx_q <= '0;
			for (int i = 0; i < FRAME_BYTES; i++) store_q[i] <= 8'h00;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (action) begin
							crc_q     <= CRC_INIT;
							crc_idx_q <= '0;
							state_q   <= F_CRC;
						end else if (win_q < WIN_W'(RX_WINDOW)) begin
							win_q <= win_q + 1'b1;
							if (!(cnt_q == '0 && rx_byte != slave_address) &&
							    cnt_q < CNT_W'(FRAME_BYTES)) begin
								store_q[cnt_q[IDX_W-1:0]] <= rx_byte;
								cnt_q <= cnt_q + 1'b1;
							end
						end
					end
				end
				F_CRC: begin
					crc_q     <= crc_byte(crc_q, store_q[crc_idx_q]);
					crc_idx_q <= crc_idx_q + 1'b1;
					if (crc_idx_q == IDX_W'(CRC_BYTES - 1)) state_q <= F_CHECK;
				end
				F_CHECK: begin
					if (!(cmd_ok && q_full)) begin
						cnt_q   <= '0;
						win_q   <= '0;
						for (int i = 0; i < FRAME_BYTES; i++) store_q[i] <= 8'h00;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

[sv/mrs_queue.sv]
// Two-entry command queue between front end and reply sequencer.
`timescale 1ns / 1ps
module mrs_queue import mrs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  q_ctl_t ctl,
	input  cmd_t   wr_cmd,
	output cmd_t   head,
	output logic   full,
	output logic   not_empty
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (ctl.push) mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (ctl.push) wr_ptr_q <= ~wr_ptr_q;
			if (ctl.pop)  rd_ptr_q <= ~rd_ptr_q;
			unique case ({ctl.push, ctl.pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/mrs_back.sv]
// Reply sequencer: emits reply bytes one per cycle unless the receiver stalls, and owns the buzzer state.
`timescale 1ns / 1ps
module mrs_back import mrs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_not_empty,
	input  cmd_t       head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] tx_byte,
	output logic       tx_last,
	output logic       buzzer
);

	logic [IDX_W-1:0] idx_q;
	logic [15:0]      crc_q;
	logic             buzz_q;
	logic             out_valid_q;
	logic [7:0]       tx_byte_q;
	logic             tx_last_q;
	logic             buzzer_q;

	logic       issue;
	logic       last;
	logic       buzz_next;
	logic [7:0] byte_d;
	logic [7:0] read_byte;
	logic [15:0] crc_next;

	assign issue = q_not_empty && (!out_valid_q || !out_stall);
	assign last  = head.is_write ? (idx_q == IDX_W'(FRAME_BYTES - 1))
	                             : (idx_q == IDX_W'(READ_BYTES - 1));
	assign pop   = issue && last;

	always_comb begin
		unique case (idx_q)
			3'd0:    read_byte = head.bytes[0];
			3'd1:    read_byte = CODE_READ;
			3'd2:    read_byte = READ_BYTECNT;
			3'd3:    read_byte = 8'h00;
			3'd4:    read_byte = {7'b0, buzz_q};
			3'd5:    read_byte = crc_q[7:0];
			3'd6:    read_byte = crc_q[15:8];
			default: read_byte = 8'h00;
		endcase
	end

	assign byte_d    = head.is_write ? head.bytes[idx_q] : read_byte;
	assign crc_next  = crc_byte((idx_q == '0) ? CRC_INIT : crc_q, byte_d);
	assign buzz_next = (head.is_write && head.bytes[2] == REG_HI &&
	                    head.bytes[3] == REG_WRITE_LO) ?
	                   (head.bytes[5] == BUZZ_ON_VALUE) : buzz_q;

	assign out_valid = out_valid_q;
	assign tx_byte   = tx_byte_q;
	assign tx_last   = tx_last_q;
	assign buzzer    = buzzer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			crc_q       <= CRC_INIT;
			buzz_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (issue) begin
			out_valid_q <= 1'b1;
			buzz_q      <= buzz_next;
			if (idx_q < IDX_W'(CRC_BYTES - 1)) crc_q <= crc_next;
			idx_q       <= last ? '0 : idx_q + 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			tx_byte_q <= byte_d;
			tx_last_q <= last;
			buzzer_q  <= buzz_next;
		end
	end

endmodule

[sv/modbus_rtu_slave_frame.sv]
// Top level of the Modbus RTU slave frame block: config register, front, queue, back.
`timescale 1ns / 1ps
// Input channel (in_valid/in_stall): one item per transfer, action plus rx_byte.
//   action 0 stores a received byte if the frame store accepts it.
//   action 1 ends the frame: the front end then runs the CRC over bytes 0..5, one
//   byte per cycle, and then checks the frame; a frame end holds the input through
//   the CRC and the check, and longer while the command queue is full.
// Output channel (out_valid/out_stall): one reply byte per transfer, tx_last on
//   the final byte, buzzer the level after the frame. The reply sequencer
//   emits one byte per cycle unless the receiver stalls (7 bytes for a read, 8 for a
//   write echo); after the check, the first byte passes the queue and output register.
// A two-entry queue sits between front and back, so new bytes are taken while a
//   reply is still going out. If the receiver stalls, the output byte holds and
//   the sequencer waits; the front end keeps running until the queue fills.
// Config channel (cfg_valid/cfg_ready): writes slave_address; always ready.
//   Write only while the block is idle.
// Reset: slave address 1, internal buzzer state off, frame store and counters
//   cleared, queue empty, no output pending; the buzzer output is not reset.
module modbus_rtu_slave_frame import mrs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] tx_byte,
	output logic       tx_last,
	output logic       buzzer,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] slave_address
);

	logic [7:0] addr_q;
	q_ctl_t     q_ctl;
	logic       q_push;
	logic       q_pop;
	cmd_t       push_cmd;
	cmd_t       head;
	logic       q_full;
	logic       q_not_empty;

	assign cfg_ready = 1'b1;
	assign q_ctl     = '{push: q_push, pop: q_pop};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) addr_q <= 8'h01;
		else if (cfg_valid && cfg_ready) addr_q <= slave_address;
	end

	mrs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.rx_byte       (rx_byte),
		.slave_address (addr_q),
		.q_full        (q_full),
		.push          (q_push),
		.push_cmd      (push_cmd)
	);

	mrs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (q_ctl),
		.wr_cmd    (push_cmd),
		.head      (head),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	mrs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.tx_byte     (tx_byte),
		.tx_last     (tx_last),
		.buzzer      (buzzer)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_not_empty) else $error("pop from empty queue");

	a_frame_end_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && action) |=> in_stall)
		else $error("frame end did not hold input");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the Modbus RTU slave frame block.
`timescale 1ns / 1ps
module testbench;
	import mrs_pkg::*;

	typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       buzz;
	} reply_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       action;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] tx_byte;
	logic       tx_last;
	logic       buzzer;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] slave_address;

	// slave model state
	frame_t     rx_frame;
	int         rx_count;
	int         win_count;
	logic       buzz_level;
	logic [7:0] own_address;

	reply_t replies_due[$];
	int     err_count;
	int     items_sent;
	bit     gaps_on;
	bit     stalls_on;
	int     stall_left;

	modbus_rtu_slave_frame u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.tx_byte      (tx_byte),
		.tx_last      (tx_last),
		.buzzer       (buzzer),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.slave_address(slave_address)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [15:0] modbus_crc(input frame_t d, input int n);
		logic [15:0] c;
		c = CRC_INIT;
		for (int i = 0; i < n; i++) begin
			c = c ^ {8'h00, d[i]};
			for (int k = 0; k < 8; k++) begin
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			end
		end
		return c;
	endfunction

	function automatic frame_t make_frame(input logic [7:0] addr, input logic [7:0] func,
			input logic [7:0] rhi, input logic [7:0] rlo, input logic [7:0] vhi,
			input logic [7:0] vlo, input bit swap);
		frame_t f;
		logic [15:0] c;
		f = '0;
		f[0] = addr;
		f[1] = func;
		f[2] = rhi;
		f[3] = rlo;
		f[4] = vhi;
		f[5] = vlo;
		c = modbus_crc(f, CRC_BYTES);
		f[6] = swap ? c[15:8] : c[7:0];
		f[7] = swap ? c[7:0] : c[15:8];
		return f;
	endfunction

	// Advances the slave model by one accepted transfer, queues expected reply bytes.
	function automatic void slave_step(input logic act, input logic [7:0] b);
		frame_t rep;
		int n;
		logic [15:0] c;
		rep = '0;
		n = 0;
		if (!act) begin
			if (win_count < RX_WINDOW) begin
				win_count++;
				if (!(rx_count == 0 && b != own_address) && rx_count < FRAME_BYTES) begin
					rx_frame[rx_count] = b;
					rx_count++;
				end
			end
			return;
		end
		c = modbus_crc(rx_frame, CRC_BYTES);
		if (((rx_frame[6] == c[7:0] && rx_frame[7] == c[15:8]) ||
		     (rx_frame[6] == c[15:8] && rx_frame[7] == c[7:0])) &&
		    rx_frame[0] == own_address) begin
			if (rx_frame[1] == CODE_READ) begin
				if (rx_frame[2] == REG_HI && rx_frame[3] == REG_READ_LO) begin
					rep[0] = own_address;
					rep[1] = CODE_READ;
					rep[2] = READ_BYTECNT;
					rep[3] = 8'h00;
					rep[4] = {7'b0, buzz_level};
					c = modbus_crc(rep, 5);
					rep[5] = c[7:0];
					rep[6] = c[15:8];
					n = READ_BYTES;
				end
			end else if (rx_frame[1] == CODE_WRITE) begin
				rep = rx_frame;
				n = FRAME_BYTES;
				if (rx_frame[2] == REG_HI && rx_frame[3] == REG_WRITE_LO)
					buzz_level = (rx_frame[5] == BUZZ_ON_VALUE);
			end
		end
		for (int k = 0; k < n; k++)
			replies_due.push_back('{data: rep[k], last: (k == n - 1), buzz: buzz_level});
		rx_frame = '0;
		rx_count = 0;
		win_count = 0;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	task automatic send_item(input logic act, input logic [7:0] b);
		int g;
		g = pick_gap();
		if (g > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		action = act;
		rx_byte = b;
		do @(posedge clk); while (in_stall);
		slave_step(act, b);
		items_sent++;
	endtask

	task automatic send_frame(input frame_t f, input int junk, input int keep, input int extra);
		logic [7:0] b;
		for (int i = 0; i < junk; i++) begin
			b = 8'($urandom_range(0, 255));
			if (b == own_address)
				b = b ^ 8'h80;
			send_item(1'b0, b);
		end
		for (int i = 0; i < keep; i++)
			send_item(1'b0, f[i]);
		for (int i = 0; i < extra; i++)
			send_item(1'b0, 8'($urandom_range(0, 255)));
		send_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	// drop valid, wait for every expected reply, then let the block settle
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_slave_address(input logic [7:0] v);
		drain();
		@(negedge clk);
		cfg_valid = 1'b1;
		slave_address = v;
		do @(posedge clk); while (!cfg_ready);
		own_address = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_directed();
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		// write to the buzzer register, value 1: buzzer on, echo
		send_frame(make_frame(own_address, CODE_WRITE, REG_HI, REG_WRITE_LO, 8'h00,
			BUZZ_ON_VALUE, 1'b0), 0, 8, 0);
		// buzzer read with CRC bytes swapped
		send_frame(make_frame(own_address, CODE_READ, REG_HI, REG_READ_LO, 8'h00, 8'h01,
			1'b1), 0, 8, 0);
		// frame end with nothing stored
		send_item(1'b1, 8'hFF);
		// short frame holding the byte extremes
		send_item(1'b0, own_address);
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hFF);
		send_item(1'b1, 8'h00);
	endtask

	task automatic test_random_frames(input int n_items);
		int target;
		int kind;
		int junk;
		int keep;
		int extra;
		int idx;
		bit drained;
		logic [7:0] func;
		logic [7:0] rhi;
		logic [7:0] rlo;
		logic [7:0] vlo;
		frame_t f;
		target = items_sent + n_items;
		drained = 1'b0;
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		while (items_sent < target) begin
			if (items_sent > target - n_items + 20) begin
				gaps_on = 1'b1;
				stalls_on = 1'b1;
			end
			if (!drained && items_sent > target - n_items / 2) begin
				drain();
				drained = 1'b1;
			end
			kind = $urandom_range(0, 99);
			junk = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
			keep = FRAME_BYTES;
			extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
			func = CODE_WRITE;
			rhi = REG_HI;
			rlo = REG_WRITE_LO;
			vlo = 8'($urandom_range(0, 255));
			if (kind < 30) begin
				func = CODE_READ;
				rlo = REG_READ_LO;
			end else if (kind < 55) begin
				if ($urandom_range(0, 1))
					vlo = BUZZ_ON_VALUE;
			end else if (kind < 65) begin
				rhi = $urandom_range(0, 1) ? REG_HI : 8'($urandom_range(0, 255));
				rlo = 8'($urandom_range(0, 255));
			end else if (kind < 72) begin
				func = CODE_READ;
				rhi = $urandom_range(0, 1) ? REG_HI : 8'($urandom_range(0, 255));
				rlo = 8'($urandom_range(0, 255));
			end else if (kind < 77) begin
				func = 8'($urandom_range(0, 255));
			end else if (kind < 88) begin
				if (kind >= 84)
					keep = $urandom_range(0, FRAME_BYTES - 1);
			end else if (kind < 93) begin
				keep = 0;
				extra = $urandom_range(0, 40);
			end else begin
				junk = $urandom_range(25, 40);
			end
			f = make_frame(own_address, func, rhi, rlo, 8'($urandom_range(0, 255)) & 8'h01,
				vlo, 1'($urandom_range(0, 1)));
			if (kind >= 77 && kind < 84) begin
				idx = $urandom_range(1, FRAME_BYTES - 1);
				f[idx] = f[idx] ^ 8'($urandom_range(1, 255));
			end
			send_frame(f, junk, keep, extra);
		end
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		int r;
		if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else begin
			out_stall = 1'b0;
			if (stalls_on) begin
				r = $urandom_range(0, 99);
				if (r < 25)
					stall_left = (r < 3) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			end
		end
	end

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (replies_due.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected reply transfer: byte %02h last %b buzzer %b",
						tx_byte, tx_last, buzzer);
			end else begin
				want = replies_due.pop_front();
				if (tx_byte !== want.data || tx_last !== want.last || buzzer !== want.buzz) begin
					err_count++;
					if (err_count <= 10)
						$display("reply error: want %02h/%b/%b got %02h/%b/%b",
							want.data, want.last, want.buzz, tx_byte, tx_last, buzzer);
				end
			end
		end
	end

	initial begin
		#(5_000_000);
		$display("modbus_rtu_slave_frame: mismatch");
		$finish;
	end

	initial begin
		in_valid = 1'b0;
		action = 1'b0;
		rx_byte = 8'h00;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		slave_address = 8'h01;
		arst_n = 1'b0;
		rx_frame = '0;
		rx_count = 0;
		win_count = 0;
		buzz_level = 1'b0;
		own_address = 8'h01;
		err_count = 0;
		items_sent = 0;
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		stall_left = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		set_slave_address(8'h00);
		test_random_frames(85);
		set_slave_address(8'hFF);
		test_random_frames(85);
		set_slave_address(8'($urandom_range(0, 255)));
		test_random_frames(85);
		set_slave_address(8'h01);
		test_random_frames(85);

		@(negedge clk);
		in_valid = 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (err_count == 0)
			$display("modbus_rtu_slave_frame: match");
		else
			$display("modbus_rtu_slave_frame: mismatch");
		$finish;
	end

endmodule
